// ===== hw/rtl/nfa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the frame allocator.
`timescale 1ns / 1ps
package nfa_pkg;

  localparam int FRAMES   = 64;
  localparam int FRAME_W  = 6;
  localparam int PROCS    = 16;
  localparam int PID_W    = 4;
  localparam int PAGE_W   = 6;
  localparam int PAGE_SH  = 10;
  localparam int VA_W     = 16;
  localparam int MODE_W   = 3;
  localparam int PT_AW    = PID_W + PAGE_W;
  localparam int PT_DEPTH = 1 << PT_AW;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 16;

  localparam logic [MODE_W-1:0] MODE_READ    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR_R = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd4;

  localparam logic [1:0] ASEL_ITEM   = 2'd0;
  localparam logic [1:0] ASEL_ALL    = 2'd1;
  localparam logic [1:0] ASEL_ROW    = 2'd2;
  localparam logic [1:0] ASEL_VICTIM = 2'd3;

  typedef struct packed {
    logic       load;
    logic [1:0] asel;
    logic       pt_we;
    logic       pt_set;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       claim;
    logic       hit_upd;
    logic       install;
    logic       make_table;
    logic       clear_r;
    logic       rel_entry;
    logic       rel_table;
    logic       res_load;
    logic       res_item;
  } nfa_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              pt_valid;
    logic              claim_free;
    logic              cnt_row_last;
    logic              cnt_all_last;
    logic              out_busy;
  } nfa_sts_t;

endpackage

// ===== hw/rtl/nfa_ctrl.sv =====
// Controller state machine that sequences lookups, claims, sweeps and result delivery.
`timescale 1ns / 1ps
module nfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  output logic               in_ready,
  input  nfa_pkg::nfa_sts_t  sts,
  output nfa_pkg::nfa_cmd_t  cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_INST  = 4'd4;
  localparam logic [3:0] S_TBL   = 4'd5;
  localparam logic [3:0] S_TCLR  = 4'd6;
  localparam logic [3:0] S_SWRD  = 4'd7;
  localparam logic [3:0] S_SWWR  = 4'd8;
  localparam logic [3:0] S_RELT  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       is_access;

  assign is_access = (sts.mode == nfa_pkg::MODE_READ) || (sts.mode == nfa_pkg::MODE_WRITE);
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.asel  = nfa_pkg::ASEL_ITEM;
    unique case (state_r)
      S_INIT: begin
        // Page table is swept to invalid after reset.
        cmd.asel    = nfa_pkg::ASEL_ALL;
        cmd.pt_we   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_all_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) state_nxt = S_DISP;
      end
      S_DISP: begin
        priority if (is_access || sts.mode == nfa_pkg::MODE_CREATE) begin
          state_nxt = S_EVAL;
        end else if (sts.mode == nfa_pkg::MODE_CLEAR_R) begin
          cmd.clear_r = 1'b1;
          state_nxt   = S_DONE;
        end else if (sts.mode == nfa_pkg::MODE_RELEASE) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_SWRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EVAL: begin
        cmd.claim = 1'b1;
        if (is_access && sts.pt_valid) begin
          cmd.hit_upd = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.asel  = nfa_pkg::ASEL_VICTIM;
          cmd.pt_we = !sts.claim_free;
          state_nxt = is_access ? S_INST : S_TBL;
        end
      end
      S_INST: begin
        cmd.pt_we   = 1'b1;
        cmd.pt_set  = 1'b1;
        cmd.install = 1'b1;
        state_nxt   = S_DONE;
      end
      S_TBL: begin
        cmd.make_table = 1'b1;
        cmd.cnt_clr    = 1'b1;
        state_nxt      = S_TCLR;
      end
      S_TCLR: begin
        cmd.asel    = nfa_pkg::ASEL_ROW;
        cmd.pt_we   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_row_last) state_nxt = S_DONE;
      end
      S_SWRD: begin
        cmd.asel  = nfa_pkg::ASEL_ROW;
        state_nxt = S_SWWR;
      end
      S_SWWR: begin
        cmd.asel      = nfa_pkg::ASEL_ROW;
        cmd.rel_entry = 1'b1;
        cmd.pt_we     = 1'b1;
        cmd.cnt_inc   = 1'b1;
        state_nxt     = sts.cnt_row_last ? S_RELT : S_SWRD;
      end
      S_RELT: begin
        cmd.rel_table = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          cmd.res_item = is_access || (sts.mode == nfa_pkg::MODE_CREATE);
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hw/rtl/nfa_datapath.sv =====
// Frame marks, page-table memory, free and NRU victim selection, and the result register.
`timescale 1ns / 1ps
module nfa_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nfa_pkg::nfa_cmd_t           cmd,
  output nfa_pkg::nfa_sts_t           sts,
  input  logic [nfa_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [nfa_pkg::OUT_W-1:0]   out_tdata
);

  logic [nfa_pkg::FRAMES-1:0]   used_r, ref_r, mod_r, tbl_r;
  logic [nfa_pkg::PT_AW-1:0]    vic_tag_mem [nfa_pkg::FRAMES];
  logic [nfa_pkg::PT_AW-1:0]    vic_tag_r;
  logic [nfa_pkg::FRAME_W-1:0]  tframe_r [nfa_pkg::PROCS];
  logic [nfa_pkg::FRAME_W:0]    pt_mem [nfa_pkg::PT_DEPTH];
  logic [nfa_pkg::FRAME_W:0]    pt_rd_r;

  logic [nfa_pkg::MODE_W-1:0]   mode_r;
  logic [nfa_pkg::PID_W-1:0]    pid_r;
  logic [nfa_pkg::PAGE_W-1:0]   page_r;
  logic [nfa_pkg::PT_AW-1:0]    cnt_r;

  logic [nfa_pkg::FRAME_W-1:0]  f_r;
  logic                         hit_r, free_r, dirty_r;
  logic                         out_valid_r;
  logic [nfa_pkg::OUT_W-1:0]    out_data_r;

  logic                         free_found;
  logic [nfa_pkg::FRAME_W-1:0]  free_idx, vic_idx, claim_f, rd_f;
  logic                         claim_dirty, hit_now, is_write;
  logic [nfa_pkg::PT_AW-1:0]    pt_addr;
  logic [nfa_pkg::FRAME_W:0]    pt_wdata;

  assign rd_f     = pt_rd_r[nfa_pkg::FRAME_W-1:0];
  assign is_write = (mode_r == nfa_pkg::MODE_WRITE);
  assign hit_now  = pt_rd_r[nfa_pkg::FRAME_W] &&
                    ((mode_r == nfa_pkg::MODE_READ) || is_write);

  // Lowest free frame, and the NRU victim: lowest class first, then lowest index.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    vic_idx    = '0;
    for (int i = nfa_pkg::FRAMES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = nfa_pkg::FRAME_W'(i);
      end
    end
    for (int c = 3; c >= 0; c--) begin
      for (int i = nfa_pkg::FRAMES - 1; i >= 0; i--) begin
        if (!tbl_r[i] && ({ref_r[i], mod_r[i]} == 2'(c))) vic_idx = nfa_pkg::FRAME_W'(i);
      end
    end
  end

  assign claim_f     = free_found ? free_idx : vic_idx;
  assign claim_dirty = !free_found && mod_r[claim_f];

  always_comb begin
    unique case (cmd.asel)
      nfa_pkg::ASEL_ITEM:   pt_addr = {pid_r, page_r};
      nfa_pkg::ASEL_ALL:    pt_addr = cnt_r;
      nfa_pkg::ASEL_ROW:    pt_addr = {pid_r, cnt_r[nfa_pkg::PAGE_W-1:0]};
      nfa_pkg::ASEL_VICTIM: pt_addr = vic_tag_r;
      default:              pt_addr = {pid_r, page_r};
    endcase
  end

  assign pt_wdata = cmd.pt_set ? {1'b1, f_r} : '0;

  always_ff @(posedge clk) begin
    if (cmd.pt_we) pt_mem[pt_addr] <= pt_wdata;
    pt_rd_r <= pt_mem[pt_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tdata[nfa_pkg::MODE_W-1:0];
      pid_r  <= in_tdata[nfa_pkg::MODE_W +: nfa_pkg::PID_W];
      page_r <= in_tdata[nfa_pkg::MODE_W + nfa_pkg::PID_W + nfa_pkg::PAGE_SH +: nfa_pkg::PAGE_W];
    end
    if (cmd.claim) begin
      hit_r   <= hit_now;
      f_r     <= hit_now ? rd_f : claim_f;
      free_r  <= !hit_now && free_found;
      dirty_r <= !hit_now && claim_dirty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            cnt_r <= '0;
    else if (cmd.cnt_clr)  cnt_r <= '0;
    else if (cmd.cnt_inc)  cnt_r <= cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ref_r  <= '0;
      mod_r  <= '0;
      tbl_r  <= '0;
    end else begin
      if (cmd.clear_r) ref_r <= ref_r & tbl_r;
      if (cmd.hit_upd) begin
        ref_r[rd_f] <= 1'b1;
        if (is_write) mod_r[rd_f] <= 1'b1;
      end
      if (cmd.install) begin
        used_r[f_r] <= 1'b1;
        tbl_r[f_r]  <= 1'b0;
        ref_r[f_r]  <= 1'b1;
        mod_r[f_r]  <= is_write;
      end
      if (cmd.make_table) begin
        used_r[f_r] <= 1'b1;
        tbl_r[f_r]  <= 1'b1;
      end
      if (cmd.rel_entry && pt_rd_r[nfa_pkg::FRAME_W]) begin
        used_r[rd_f] <= 1'b0;
        ref_r[rd_f]  <= 1'b0;
        mod_r[rd_f]  <= 1'b0;
        tbl_r[rd_f]  <= 1'b0;
      end
      if (cmd.rel_table) begin
        used_r[tframe_r[pid_r]] <= 1'b0;
        ref_r[tframe_r[pid_r]]  <= 1'b0;
        mod_r[tframe_r[pid_r]]  <= 1'b0;
        tbl_r[tframe_r[pid_r]]  <= 1'b0;
      end
    end
  end

  // The frame marks hold still from dispatch to evaluation, so the victim's owner
  // and page read here during dispatch are the ones the evaluation step needs.
  always_ff @(posedge clk) begin
    if (cmd.install) vic_tag_mem[f_r] <= {pid_r, page_r};
    vic_tag_r <= vic_tag_mem[claim_f];
    if (cmd.make_table) tframe_r[pid_r] <= f_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r <= cmd.res_item ?
                    {7'd0, dirty_r, free_r, f_r, hit_r} : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.mode         = mode_r;
  assign sts.pt_valid     = pt_rd_r[nfa_pkg::FRAME_W];
  assign sts.claim_free   = free_found;
  assign sts.cnt_row_last = &cnt_r[nfa_pkg::PAGE_W-1:0];
  assign sts.cnt_all_last = &cnt_r;
  assign sts.out_busy     = out_valid_r && !out_tready;

`ifndef SYNTHESIS
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && (out_data_r[7] || out_data_r[8])))
    else $error("hit result reports a claim");
  a_install: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.install |=> (used_r[f_r] && ref_r[f_r] && !tbl_r[f_r]))
    else $error("installed frame not marked");
  a_rel_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rel_table |=> !used_r[tframe_r[pid_r]])
    else $error("released table frame still used");
  a_clear_r: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_r |=> ((ref_r & ~tbl_r) == '0))
    else $error("referenced bit survived clear");
`endif

endmodule

// ===== hw/rtl/nru_frame_allocator_core.sv =====
// Top level of the NRU frame allocator: stream ports, controller and datapath.
// One word is worked at a time.
// The page-table memory (one port, registered read) sets the miss and sweep lengths.
// Reset (rst_n, synchronous, low) clears all frame marks, then a pass over all 1024
// page-table entries invalidates them; in_tready stays low until it completes.
`timescale 1ns / 1ps
module nru_frame_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [nfa_pkg::IN_W-1:0]   in_tdata,   // mode[2:0], pid[6:3], virtual_address[22:7]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [nfa_pkg::OUT_W-1:0]  out_tdata   // hit[0], frame[6:1], from_free[7], victim_dirty[8]
);

  nfa_pkg::nfa_cmd_t cmd;
  nfa_pkg::nfa_sts_t sts;
  logic              ready;

  assign in_tready = ready;

  nfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid && ready),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nfa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sim/tb_nru_frame_allocator_core.sv =====
// Self-checking testbench for the NRU frame allocator core: random and directed words.
`timescale 1ns / 1ps
module tb_nru_frame_allocator_core;

  typedef struct packed {
    logic                         victim_dirty;
    logic                         from_free;
    logic [nfa_pkg::FRAME_W-1:0]  frame;
    logic                         hit;
  } alloc_res_t;

  typedef struct {
    logic [nfa_pkg::IN_W-1:0] word;
    bit                       drain;
  } pend_t;

  localparam int LIMIT_CYCLES = 800000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [nfa_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [nfa_pkg::OUT_W-1:0] out_tdata;

  nru_frame_allocator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #2 clk = ~clk;

  // Shadow copy of the allocator state.
  bit                           f_used [nfa_pkg::FRAMES];
  bit                           f_ref [nfa_pkg::FRAMES];
  bit                           f_mod [nfa_pkg::FRAMES];
  bit                           f_tab [nfa_pkg::FRAMES];
  bit                           f_owner_known [nfa_pkg::FRAMES];
  logic [nfa_pkg::PID_W-1:0]    f_owner [nfa_pkg::FRAMES];
  logic [nfa_pkg::PAGE_W-1:0]   f_page [nfa_pkg::FRAMES];
  bit                           pg_valid [nfa_pkg::PT_DEPTH];
  logic [nfa_pkg::FRAME_W-1:0]  pg_frame [nfa_pkg::PT_DEPTH];
  logic [nfa_pkg::FRAME_W-1:0]  tab_frame [nfa_pkg::PROCS];
  bit                           tab_made [nfa_pkg::PROCS];

  pend_t      pending_words [$];
  alloc_res_t expected_results [$];
  int sent_words = 0;
  int rcvd_words = 0;
  int errors = 0;

  function automatic int lowest_free();
    for (int i = 0; i < nfa_pkg::FRAMES; i++)
      if (!f_used[i]) return i;
    return -1;
  endfunction

  function automatic int nru_victim();
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < nfa_pkg::FRAMES; i++)
        if (!f_tab[i] && (2 * f_ref[i] + f_mod[i]) == c) return i;
    return 0;
  endfunction

  function automatic void claim(output int f, output bit ffree, output bit dirty);
    int fr;
    fr = lowest_free();
    ffree = 0;
    dirty = 0;
    if (fr >= 0) begin
      ffree = 1;
      f = fr;
    end else begin
      f = nru_victim();
      dirty = f_mod[f];
      pg_valid[{f_owner[f], f_page[f]}] = 0;
    end
  endfunction

  function automatic void free_frame(int f);
    f_used[f] = 0;
    f_ref[f] = 0;
    f_mod[f] = 0;
    f_tab[f] = 0;
  endfunction

  // Words that would read a never-written store entry are not sent.
  function automatic bit word_allowed(logic [nfa_pkg::MODE_W-1:0] mode,
                                      logic [nfa_pkg::PID_W-1:0] pid,
                                      logic [nfa_pkg::VA_W-1:0] va);
    bit needs_claim;
    bit all_tab;
    needs_claim = (mode == nfa_pkg::MODE_CREATE) ||
                  ((mode == nfa_pkg::MODE_READ || mode == nfa_pkg::MODE_WRITE) &&
                   !pg_valid[{pid, va[nfa_pkg::VA_W-1:nfa_pkg::PAGE_SH]}]);
    if (mode == nfa_pkg::MODE_RELEASE && !tab_made[pid]) return 0;
    if (!needs_claim || lowest_free() >= 0) return 1;
    all_tab = 1;
    for (int i = 0; i < nfa_pkg::FRAMES; i++)
      if (!f_tab[i]) all_tab = 0;
    return !(all_tab && !f_owner_known[0]);
  endfunction

  function automatic alloc_res_t allocate(logic [nfa_pkg::MODE_W-1:0] mode,
                                          logic [nfa_pkg::PID_W-1:0] pid,
                                          logic [nfa_pkg::VA_W-1:0] va);
    alloc_res_t r;
    logic [nfa_pkg::PAGE_W-1:0] pg;
    int f;
    bit ffree, dirty;
    r = '0;
    pg = va[nfa_pkg::VA_W-1:nfa_pkg::PAGE_SH];
    case (mode)
      nfa_pkg::MODE_CLEAR_R: begin
        for (int i = 0; i < nfa_pkg::FRAMES; i++)
          if (!f_tab[i]) f_ref[i] = 0;
      end
      nfa_pkg::MODE_READ, nfa_pkg::MODE_WRITE: begin
        if (pg_valid[{pid, pg}]) begin
          f = int'(pg_frame[{pid, pg}]);
          f_ref[f] = 1;
          if (mode == nfa_pkg::MODE_WRITE) f_mod[f] = 1;
          r.hit = 1;
          r.frame = nfa_pkg::FRAME_W'(f);
        end else begin
          claim(f, ffree, dirty);
          f_used[f] = 1;
          f_tab[f] = 0;
          f_owner[f] = pid;
          f_page[f] = pg;
          f_owner_known[f] = 1;
          f_ref[f] = 1;
          f_mod[f] = (mode == nfa_pkg::MODE_WRITE);
          pg_valid[{pid, pg}] = 1;
          pg_frame[{pid, pg}] = nfa_pkg::FRAME_W'(f);
          r.frame = nfa_pkg::FRAME_W'(f);
          r.from_free = ffree;
          r.victim_dirty = dirty;
        end
      end
      nfa_pkg::MODE_RELEASE: begin
        for (int i = 0; i < (1 << nfa_pkg::PAGE_W); i++) begin
          if (pg_valid[{pid, i[nfa_pkg::PAGE_W-1:0]}])
            free_frame(int'(pg_frame[{pid, i[nfa_pkg::PAGE_W-1:0]}]));
          pg_valid[{pid, i[nfa_pkg::PAGE_W-1:0]}] = 0;
        end
        free_frame(int'(tab_frame[pid]));
      end
      nfa_pkg::MODE_CREATE: begin
        claim(f, ffree, dirty);
        f_used[f] = 1;
        f_tab[f] = 1;
        tab_frame[pid] = nfa_pkg::FRAME_W'(f);
        tab_made[pid] = 1;
        for (int i = 0; i < (1 << nfa_pkg::PAGE_W); i++)
          pg_valid[{pid, i[nfa_pkg::PAGE_W-1:0]}] = 0;
        r.frame = nfa_pkg::FRAME_W'(f);
        r.from_free = ffree;
        r.victim_dirty = dirty;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_word(logic [nfa_pkg::MODE_W-1:0] mode,
                            logic [nfa_pkg::PID_W-1:0] pid,
                            logic [nfa_pkg::VA_W-1:0] va, bit drain);
    pend_t p;
    p.word = {1'b0, va, pid, mode};
    p.drain = drain;
    expected_results.push_back(allocate(mode, pid, va));
    pending_words.push_back(p);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Sender: one word in flight, random gaps, and a drain hold when marked.
  int in_gap = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    pend_t head;
    if (rst_n) begin
      if (in_tvalid && in_tready) sent_words++;
      if (in_tvalid && !in_tready) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > 0 &&
                   !(pending_words[0].drain && rcvd_words != sent_words)) begin
        head = pending_words.pop_front();
        in_tdata <= head.word;
        in_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          in_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 40);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, checks each word against the oldest prediction.
  int out_gap = 0;
  always @(posedge clk) begin
    alloc_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[8:0];
        rcvd_words <= rcvd_words + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit)
            $display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
          if (got.frame !== want.frame)
            $display("%0t: frame expected %0d got %0d", $time, want.frame, got.frame);
          if (got.from_free !== want.from_free)
            $display("%0t: from_free expected %0d got %0d", $time, want.from_free,
                     got.from_free);
          if (got.victim_dirty !== want.victim_dirty)
            $display("%0t: victim_dirty expected %0d got %0d", $time, want.victim_dirty,
                     got.victim_dirty);
          if (got !== want) errors++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [nfa_pkg::MODE_W-1:0] mode;
    logic [nfa_pkg::PID_W-1:0] pid;
    logic [nfa_pkg::VA_W-1:0] va;
    int r, pid_span, page_span;
    for (int i = 0; i < nfa_pkg::FRAMES; i++) begin
      f_used[i] = 0; f_ref[i] = 0; f_mod[i] = 0; f_tab[i] = 0;
      f_owner_known[i] = 0; f_owner[i] = '0; f_page[i] = '0;
    end
    for (int i = 0; i < nfa_pkg::PT_DEPTH; i++) begin
      pg_valid[i] = 0;
      pg_frame[i] = '0;
    end
    for (int i = 0; i < nfa_pkg::PROCS; i++) begin
      tab_frame[i] = '0;
      tab_made[i] = 0;
    end

    // Directed: table creation, miss, hits, extremes, clear, release, bad modes.
    queue_word(nfa_pkg::MODE_CREATE, 4'd0, 16'h0000, 0);
    queue_word(nfa_pkg::MODE_CREATE, 4'd15, 16'hFFFF, 0);
    queue_word(nfa_pkg::MODE_READ, 4'd0, 16'h0000, 0);
    queue_word(nfa_pkg::MODE_WRITE, 4'd0, 16'h03FF, 0);
    queue_word(nfa_pkg::MODE_READ, 4'd0, 16'h0001, 0);
    queue_word(nfa_pkg::MODE_WRITE, 4'd15, 16'hFFFF, 0);
    queue_word(nfa_pkg::MODE_READ, 4'd15, 16'hFC00, 0);
    queue_word(nfa_pkg::MODE_READ, 4'd15, 16'h5555, 0);
    queue_word(nfa_pkg::MODE_WRITE, 4'd0, 16'hAAAA, 0);
    queue_word(nfa_pkg::MODE_CLEAR_R, 4'd0, 16'h0000, 0);
    queue_word(nfa_pkg::MODE_READ, 4'd0, 16'h0000, 0);
    queue_word(3'd5, 4'd15, 16'hFFFF, 0);
    queue_word(3'd6, 4'd3, 16'h1234, 0);
    queue_word(3'd7, 4'd9, 16'h8000, 0);
    queue_word(nfa_pkg::MODE_RELEASE, 4'd15, 16'h0000, 1);
    queue_word(nfa_pkg::MODE_READ, 4'd15, 16'hFFFF, 0);
    queue_word(nfa_pkg::MODE_CREATE, 4'd0, 16'h0000, 0);
    queue_word(nfa_pkg::MODE_READ, 4'd0, 16'h0000, 0);

    pid_span = 3;
    page_span = 20;
    for (int n = 0; n < 800; n++) begin
      if (n % 100 == 0) begin
        pid_span = $urandom_range(1, 15);
        page_span = $urandom_range(2, 63);
      end
      do begin
        r = $urandom_range(0, 99);
        pid = nfa_pkg::PID_W'($urandom_range(0, pid_span));
        va = {6'($urandom_range(0, page_span)), 10'($urandom)};
        if (r < 72) mode = nfa_pkg::MODE_W'($urandom_range(0, 1));
        else if (r < 80) mode = nfa_pkg::MODE_CREATE;
        else if (r < 87) mode = nfa_pkg::MODE_RELEASE;
        else if (r < 92) mode = nfa_pkg::MODE_CLEAR_R;
        else if (r < 96) mode = nfa_pkg::MODE_W'($urandom_range(5, 7));
        else begin
          mode = nfa_pkg::MODE_W'($urandom_range(0, 4));
          pid = nfa_pkg::PID_W'($urandom);
          va = nfa_pkg::VA_W'($urandom);
        end
      end while (!word_allowed(mode, pid, va));
      queue_word(mode, pid, va, (n % 250) == 125);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_words.size() == 0 && expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
